// ===== rtl/rsp_pkg.sv =====
// Types, constants and helpers shared by the rocking step planner.
`default_nettype none

package rsp_pkg;

  typedef enum logic [1:0] {
    ModeIdle    = 2'd0,
    ModeQstatic = 2'd1,
    ModeRocking = 2'd2
  } rsp_mode_e;

  typedef enum logic [1:0] {
    CfgTiltMin   = 2'd0,
    CfgSpinLimit = 2'd1,
    CfgCosStep   = 2'd2,
    CfgSinStep   = 2'd3
  } rsp_cfg_idx_e;

  localparam int unsigned CfgDataW = 16;

  localparam logic [14:0]        TiltMinRst   = 15'd715;
  localparam logic [14:0]        SpinLimitRst = 15'd2048;
  localparam logic signed [15:0] CosStepRst   = 16'sd28378;
  localparam logic signed [15:0] SinStepRst   = 16'sd16384;

  // Q1.15 products: round half up before dropping the fraction
  localparam int unsigned        FracBits = 15;
  localparam logic signed [41:0] RoundAdd = 42'sd16384;

  typedef struct packed {
    logic [14:0]        tilt_min;
    logic [14:0]        spin_rate_limit;
    logic signed [15:0] cos_step;
    logic signed [15:0] sin_step;
  } rsp_cfg_t;

  // work handed from the front to the back
  typedef struct packed {
    logic               rpt;
    logic               neg;
    logic signed [24:0] vx;
    logic signed [24:0] vy;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] tz;
    logic [15:0]        step;
    logic [15:0]        idx;
    logic [31:0]        stamp;
  } rsp_job_t;

  typedef struct packed {
    logic               rpt;
    logic               neg;
    logic signed [40:0] pcx;
    logic signed [40:0] psx;
    logic signed [40:0] pcy;
    logic signed [40:0] psy;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic signed [23:0] tz;
    logic [15:0]        step;
    logic [15:0]        idx;
    logic [31:0]        stamp;
  } rsp_prod_t;

  typedef struct packed {
    logic [15:0]        step;
    logic [15:0]        idx;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [23:0] tz;
    logic [31:0]        stamp;
  } rsp_cmd_t;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    logic signed [23:0] r;
    if (v > 28'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsp_if.sv =====
// Valid/ready channel interfaces for planner inputs and commands.
`default_nettype none

interface rsp_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] tilt;
  logic               point_contact;
  logic signed [15:0] spin_rate;
  logic signed [23:0] contact_x;
  logic signed [23:0] contact_y;
  logic signed [23:0] contact_z;
  logic signed [23:0] apex_x;
  logic signed [23:0] apex_y;
  logic signed [23:0] apex_z;
  logic [31:0]        stamp;

  modport source (
    output valid, cmd, tilt, point_contact, spin_rate, contact_x, contact_y, contact_z,
           apex_x, apex_y, apex_z, stamp,
    input  ready
  );
  modport sink (
    input  valid, cmd, tilt, point_contact, spin_rate, contact_x, contact_y, contact_z,
           apex_x, apex_y, apex_z, stamp,
    output ready
  );
endinterface

interface rsp_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        step_number;
  logic [15:0]        command_index;
  logic signed [23:0] target_x;
  logic signed [23:0] target_y;
  logic signed [23:0] target_z;
  logic [31:0]        stamp_out;
  logic               repeated;

  modport source (
    output valid, step_number, command_index, target_x, target_y, target_z, stamp_out,
           repeated,
    input  ready
  );
  modport sink (
    input  valid, step_number, command_index, target_x, target_y, target_z, stamp_out,
           repeated,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rsp_front.sv =====
// Front end: accepts samples and triggers, classifies, keeps planner state, issues jobs.
`default_nettype none

module rsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsp_pkg::rsp_cfg_t cfg_i,
  rsp_in_if.sink            in_ch,
  input  logic              full_i,
  output logic              push_o,
  output rsp_pkg::rsp_job_t job_o
);
  import rsp_pkg::*;

  rsp_mode_e   mode_q, mode_d, cls;
  logic        dir_q, dir_d;
  logic        plan_q, plan_d;
  logic        pend_q, pend_d;
  logic [15:0] step_q, step_d;
  logic [15:0] idx_q, idx_d;

  logic               accept;
  logic               tilt_low;
  logic signed [16:0] rate_ext;
  logic [16:0]        rate_abs;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;

  assign tilt_low = $signed(in_ch.tilt) < $signed({1'b0, cfg_i.tilt_min});
  assign rate_ext = {in_ch.spin_rate[15], in_ch.spin_rate};
  assign rate_abs = rate_ext[16] ? 17'(-rate_ext) : 17'(rate_ext);

  always_comb begin
    if (tilt_low || !in_ch.point_contact) begin
      cls = ModeIdle;
    end else if (rate_abs < {2'b00, cfg_i.spin_rate_limit}) begin
      cls = ModeQstatic;
    end else begin
      cls = ModeRocking;
    end
  end

  always_comb begin
    mode_d = mode_q;
    dir_d  = dir_q;
    plan_d = plan_q;
    pend_d = pend_q;
    step_d = step_q;
    idx_d  = idx_q;
    push_o = 1'b0;

    job_o.rpt   = 1'b0;
    job_o.neg   = dir_q;
    job_o.vx    = 25'({in_ch.apex_x[23], in_ch.apex_x} - {in_ch.contact_x[23], in_ch.contact_x});
    job_o.vy    = 25'({in_ch.apex_y[23], in_ch.apex_y} - {in_ch.contact_y[23], in_ch.contact_y});
    job_o.cx    = in_ch.contact_x;
    job_o.cy    = in_ch.contact_y;
    job_o.tz    = in_ch.apex_z;
    job_o.idx   = idx_q;
    job_o.stamp = in_ch.stamp;

    if (accept) begin
      if (in_ch.cmd) begin
        if (!plan_q) begin
          plan_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end else begin
        if (mode_q == ModeRocking && cls == ModeQstatic) begin
          step_d = step_q + 16'd1;
        end
        if (cls == ModeIdle) begin
          pend_d = 1'b0;
          step_d = '0;
          if (mode_q != ModeIdle) begin
            plan_d = 1'b0;
          end
        end
        mode_d = cls;
        if (cls == ModeQstatic && plan_q) begin
          push_o = 1'b1;
          if (pend_q) begin
            job_o.rpt = 1'b1;
          end else begin
            dir_d  = !dir_q;
            idx_d  = idx_q + 16'd1;
            pend_d = 1'b1;
          end
        end
      end
    end
    job_o.step = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      dir_q  <= 1'b0;
      plan_q <= 1'b0;
      pend_q <= 1'b0;
      step_q <= '0;
      idx_q  <= '0;
    end else begin
      mode_q <= mode_d;
      dir_q  <= dir_d;
      plan_q <= plan_d;
      pend_q <= pend_d;
      step_q <= step_d;
      idx_q  <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsp_fifo.sv =====
// Job queue between the front end and the back end.
`default_nettype none

module rsp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsp_pkg::rsp_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output rsp_pkg::rsp_job_t job_o
);
  import rsp_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  rsp_job_t        mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = cnt_q == CW'(Depth);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rsp_back.sv =====
// Back end: rotation multiply stage, round/offset/saturate, held command and output register.
`default_nettype none

module rsp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsp_pkg::rsp_cfg_t cfg_i,
  input  logic              valid_i,
  input  rsp_pkg::rsp_job_t job_i,
  output logic              pop_o,
  rsp_out_if.source         out_ch
);
  import rsp_pkg::*;

  logic      en;
  logic      va_q, oval_q, orep_q;
  rsp_prod_t pa_q, pa_d;
  rsp_cmd_t  held_q, ocmd_q, new_cmd;

  logic signed [41:0] sum_x, sum_y, rnd_x, rnd_y;
  logic signed [26:0] rx, ry;
  logic signed [27:0] tx_w, ty_w;

  assign en    = !oval_q || out_ch.ready;
  assign pop_o = en && valid_i;

  always_comb begin
    pa_d.rpt   = job_i.rpt;
    pa_d.neg   = job_i.neg;
    pa_d.pcx   = cfg_i.cos_step * job_i.vx;
    pa_d.psx   = cfg_i.sin_step * job_i.vx;
    pa_d.pcy   = cfg_i.cos_step * job_i.vy;
    pa_d.psy   = cfg_i.sin_step * job_i.vy;
    pa_d.cx    = job_i.cx;
    pa_d.cy    = job_i.cy;
    pa_d.tz    = job_i.tz;
    pa_d.step  = job_i.step;
    pa_d.idx   = job_i.idx;
    pa_d.stamp = job_i.stamp;
  end

  // neg set: sine enters with a minus sign
  always_comb begin
    if (pa_q.neg) begin
      sum_x = {pa_q.pcx[40], pa_q.pcx} + {pa_q.psy[40], pa_q.psy};
      sum_y = {pa_q.pcy[40], pa_q.pcy} - {pa_q.psx[40], pa_q.psx};
    end else begin
      sum_x = {pa_q.pcx[40], pa_q.pcx} - {pa_q.psy[40], pa_q.psy};
      sum_y = {pa_q.pcy[40], pa_q.pcy} + {pa_q.psx[40], pa_q.psx};
    end
    rnd_x = sum_x + RoundAdd;
    rnd_y = sum_y + RoundAdd;
    rx    = rnd_x[41:FracBits];
    ry    = rnd_y[41:FracBits];
    tx_w  = {{4{pa_q.cx[23]}}, pa_q.cx} + {rx[26], rx};
    ty_w  = {{4{pa_q.cy[23]}}, pa_q.cy} + {ry[26], ry};

    new_cmd.step  = pa_q.step;
    new_cmd.idx   = pa_q.idx;
    new_cmd.tx    = sat24(tx_w);
    new_cmd.ty    = sat24(ty_w);
    new_cmd.tz    = pa_q.tz;
    new_cmd.stamp = pa_q.stamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      oval_q <= 1'b0;
    end else if (en) begin
      va_q   <= valid_i;
      oval_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pa_q <= pa_d;
    end
    if (en && va_q) begin
      if (pa_q.rpt) begin
        ocmd_q <= held_q;
        orep_q <= 1'b1;
      end else begin
        ocmd_q <= new_cmd;
        orep_q <= 1'b0;
        held_q <= new_cmd;
      end
    end
  end

  assign out_ch.valid         = oval_q;
  assign out_ch.step_number   = ocmd_q.step;
  assign out_ch.command_index = ocmd_q.idx;
  assign out_ch.target_x      = ocmd_q.tx;
  assign out_ch.target_y      = ocmd_q.ty;
  assign out_ch.target_z      = ocmd_q.tz;
  assign out_ch.stamp_out     = ocmd_q.stamp;
  assign out_ch.repeated      = orep_q;

endmodule

`default_nettype wire

// ===== rtl/rocking_step_planner.sv =====
// Rocking step planner top level: configuration registers, front end, job queue, back end.
//
// Takes one input transfer per cycle while the job queue is not full. A sample or trigger
// is classified and the planner state updated in the cycle it is accepted; a sample that
// plans or repeats a command queues a job, which goes through the multiply register and
// the output register. Throughput is one item per cycle while the job queue has room, set
// by the state update in the front end; the back end is a two-stage pipeline
// (rotation multiplies, then round/offset/saturate into the output register). The
// FifoDepth-entry job queue absorbs output stalls; input ready drops only when it is full.
// Configuration writes take effect on the next cycle and are meant to happen while idle.
`default_nettype none

module rocking_step_planner #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [rsp_pkg::CfgDataW-1:0]  cfg_data_i,
  rsp_in_if.sink                        in_ch,
  rsp_out_if.source                     out_ch
);
  import rsp_pkg::*;

  rsp_cfg_t cfg_q;
  logic     push, full, pop, fifo_valid;
  rsp_job_t push_job, head_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tilt_min        <= TiltMinRst;
      cfg_q.spin_rate_limit <= SpinLimitRst;
      cfg_q.cos_step        <= CosStepRst;
      cfg_q.sin_step        <= SinStepRst;
    end else if (cfg_we_i) begin
      unique case (rsp_cfg_idx_e'(cfg_idx_i))
        CfgTiltMin:   cfg_q.tilt_min        <= cfg_data_i[14:0];
        CfgSpinLimit: cfg_q.spin_rate_limit <= cfg_data_i[14:0];
        CfgCosStep:   cfg_q.cos_step        <= cfg_data_i;
        CfgSinStep:   cfg_q.sin_step        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rsp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  rsp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .job_o   (head_job)
  );

  rsp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (fifo_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/rsp_checker.sv =====
// Port-level assertions for the rocking step planner, bound to the top level.
`default_nettype none

module rsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_index_i,
  input logic [23:0] out_target_x_i,
  input logic        out_repeated_i
);

  logic        xfer;
  logic        have_q;
  logic [15:0] last_q;

  assign xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      last_q <= '0;
    end else if (xfer) begin
      have_q <= 1'b1;
      last_q <= out_index_i;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("command valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_index_i) && $stable(out_target_x_i)
                                    && $stable(out_repeated_i))
    else $error("command changed while stalled");

  // a repeat re-sends the last command
  a_repeat_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_repeated_i |-> have_q && out_index_i == last_q)
    else $error("repeated command index mismatch");

  // fresh commands are numbered consecutively
  a_fresh_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !out_repeated_i && have_q |-> out_index_i == last_q + 16'd1)
    else $error("command index skipped");

endmodule

bind rocking_step_planner rsp_checker u_rsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .out_index_i    (out_ch.command_index),
  .out_target_x_i (out_ch.target_x),
  .out_repeated_i (out_ch.repeated)
);

`default_nettype wire

// ===== test/rsp_command_check.sv =====
// Command checker for the rocking step planner: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module rsp_command_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [rsp_pkg::CfgDataW-1:0] cfg_data_i,
  rsp_in_if                            in_ch,
  rsp_out_if                           out_ch,
  output int unsigned                  fail_count_o,
  output int unsigned                  outstanding_o
);
  import rsp_pkg::*;

  typedef struct packed {
    logic [15:0]        step;
    logic [15:0]        idx;
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic signed [23:0] tz;
    logic [31:0]        stamp;
    logic               rpt;
  } plan_cmd_t;

  rsp_cfg_t    cfg;
  rsp_mode_e   mode;
  logic        dir_pos;
  logic [15:0] step_cnt;
  logic [15:0] next_idx;
  logic        planning;
  logic        ack_due;
  plan_cmd_t   held;
  plan_cmd_t   planned_q[$];
  int unsigned mismatches;

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // Advance the planner state by one accepted item; queue any command it causes.
  function automatic void advance_planner(input logic trig, input logic signed [15:0] tilt,
                                          input logic contact, input logic signed [15:0] spin,
                                          input logic signed [23:0] cx, input logic signed [23:0] cy,
                                          input logic signed [23:0] cz, input logic signed [23:0] ax,
                                          input logic signed [23:0] ay, input logic signed [23:0] az,
                                          input logic [31:0] stamp);
    rsp_mode_e nxt;
    int        tilt_v;
    int        rate;
    longint    vx, vy, vz, c, s, rx, ry;
    plan_cmd_t cmd;
    if (trig) begin
      if (!planning) begin
        planning = 1'b1;
      end else begin
        ack_due = 1'b0;
      end
      return;
    end
    tilt_v = int'(tilt);
    rate = int'(spin);
    if (rate < 0) rate = -rate;
    if (tilt_v < int'(cfg.tilt_min) || !contact) begin
      nxt = ModeIdle;
    end else if (rate < int'(cfg.spin_rate_limit)) begin
      nxt = ModeQstatic;
    end else begin
      nxt = ModeRocking;
    end
    if (mode == ModeRocking && nxt == ModeQstatic) step_cnt = step_cnt + 16'd1;
    if (nxt == ModeIdle) begin
      ack_due = 1'b0;
      step_cnt = '0;
      if (mode != ModeIdle) planning = 1'b0;
    end
    mode = nxt;
    if (mode != ModeQstatic || !planning) return;
    if (ack_due) begin
      cmd = held;
      cmd.rpt = 1'b1;
      planned_q.push_back(cmd);
      return;
    end
    dir_pos = !dir_pos;
    vx = longint'(ax) - longint'(cx);
    vy = longint'(ay) - longint'(cy);
    vz = longint'(az) - longint'(cz);
    c = longint'(cfg.cos_step);
    s = dir_pos ? longint'(cfg.sin_step) : -longint'(cfg.sin_step);
    // Q1.15 round half up: floor((p + 2^14) / 2^15)
    rx = (c * vx - s * vy + 64'sd16384) >>> 15;
    ry = (s * vx + c * vy + 64'sd16384) >>> 15;
    held.step = step_cnt;
    held.idx = next_idx;
    held.tx = clip24(longint'(cx) + rx);
    held.ty = clip24(longint'(cy) + ry);
    held.tz = clip24(longint'(cz) + vz);
    held.stamp = stamp;
    held.rpt = 1'b0;
    next_idx = next_idx + 16'd1;
    ack_due = 1'b1;
    planned_q.push_back(held);
  endfunction

  function automatic void check_command(input plan_cmd_t got);
    plan_cmd_t want;
    if (planned_q.size() == 0) begin
      if (mismatches < 10) begin
        $display("%0t: command transfer with none predicted: step %0d idx %0d x %0d y %0d z %0d",
                 $realtime, got.step, got.idx, got.tx, got.ty, got.tz);
      end
      mismatches++;
      return;
    end
    want = planned_q.pop_front();
    if (got.step != want.step || got.idx != want.idx || got.tx != want.tx ||
        got.ty != want.ty || got.tz != want.tz || got.stamp != want.stamp ||
        got.rpt != want.rpt) begin
      if (mismatches < 10) begin
        $display("%0t: command mismatch expected step %0d idx %0d x %0d y %0d z %0d stamp %h rpt %0b",
                 $realtime, want.step, want.idx, want.tx, want.ty, want.tz, want.stamp, want.rpt);
        $display("%0t: command mismatch actual   step %0d idx %0d x %0d y %0d z %0d stamp %h rpt %0b",
                 $realtime, got.step, got.idx, got.tx, got.ty, got.tz, got.stamp, got.rpt);
      end
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.tilt_min = TiltMinRst;
      cfg.spin_rate_limit = SpinLimitRst;
      cfg.cos_step = CosStepRst;
      cfg.sin_step = SinStepRst;
      mode = ModeIdle;
      dir_pos = 1'b0;
      step_cnt = '0;
      next_idx = '0;
      planning = 1'b0;
      ack_due = 1'b0;
      held = '0;
      planned_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (rsp_cfg_idx_e'(cfg_idx_i))
          CfgTiltMin: cfg.tilt_min = cfg_data_i[14:0];
          CfgSpinLimit: cfg.spin_rate_limit = cfg_data_i[14:0];
          CfgCosStep: cfg.cos_step = cfg_data_i;
          CfgSinStep: cfg.sin_step = cfg_data_i;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        check_command({out_ch.step_number, out_ch.command_index, out_ch.target_x,
                       out_ch.target_y, out_ch.target_z, out_ch.stamp_out, out_ch.repeated});
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_planner(in_ch.cmd, in_ch.tilt, in_ch.point_contact, in_ch.spin_rate,
                        in_ch.contact_x, in_ch.contact_y, in_ch.contact_z,
                        in_ch.apex_x, in_ch.apex_y, in_ch.apex_z, in_ch.stamp);
      end
      fail_count_o <= mismatches;
      outstanding_o <= planned_q.size();
    end
  end

endmodule

// ===== test/rocking_step_planner_test.sv =====
// Testbench top for the rocking step planner: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module rocking_step_planner_test;
  import rsp_pkg::*;

  localparam logic CmdSample  = 1'b0;
  localparam logic CmdTrigger = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] tilt;
    logic               point_contact;
    logic signed [15:0] spin_rate;
    logic signed [23:0] contact_x;
    logic signed [23:0] contact_y;
    logic signed [23:0] contact_z;
    logic signed [23:0] apex_x;
    logic signed [23:0] apex_y;
    logic signed [23:0] apex_z;
    logic [31:0]        stamp;
  } cone_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                calm;
  int unsigned         fail_count;
  int unsigned         outstanding;
  int                  cur_tilt_min;
  int                  cur_spin_limit;

  rsp_in_if  in_ch ();
  rsp_out_if out_ch ();

  rocking_step_planner dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  rsp_command_check cmd_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // command side back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= calm || $urandom_range(99) >= 28;
    end
  end

  function automatic logic signed [23:0] pick_pos();
    logic signed [23:0] v;
    case ($urandom_range(3))
      0: v = 24'($urandom());
      1: begin
        case ($urandom_range(3))
          0: v = 24'sh7FFFFF;
          1: v = 24'sh800000;
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = 24'($urandom_range(262143) - 131072);
    endcase
    return v;
  endfunction

  function automatic cone_item_t pick_trigger();
    cone_item_t it;
    it.cmd = CmdTrigger;
    it.tilt = 16'($urandom());
    it.point_contact = 1'($urandom_range(1));
    it.spin_rate = 16'($urandom());
    it.contact_x = pick_pos();
    it.contact_y = pick_pos();
    it.contact_z = pick_pos();
    it.apex_x = pick_pos();
    it.apex_y = pick_pos();
    it.apex_z = pick_pos();
    it.stamp = $urandom();
    return it;
  endfunction

  // Sample of the given class under current thresholds; Qstatic at limit 0 is rocking.
  function automatic cone_item_t pick_sample(input rsp_mode_e kind);
    cone_item_t it;
    int         mag;
    it = pick_trigger();
    it.cmd = CmdSample;
    if (kind == ModeQstatic && cur_spin_limit == 0) kind = ModeRocking;
    if (kind == ModeIdle) begin
      if ($urandom_range(1)) begin
        it.point_contact = 1'b0;
      end else begin
        it.point_contact = 1'b1;
        it.tilt = 16'($urandom_range(cur_tilt_min + 32767, 0) - 32768);
      end
    end else begin
      it.point_contact = 1'b1;
      it.tilt = 16'($urandom_range(32767, cur_tilt_min));
      if (kind == ModeQstatic) begin
        mag = $urandom_range(cur_spin_limit - 1, 0);
      end else begin
        mag = $urandom_range(32768, cur_spin_limit);
      end
      it.spin_rate = 16'($urandom_range(1) ? -mag : mag);
    end
    return it;
  endfunction

  task automatic send_item(input cone_item_t it);
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= it.cmd;
    in_ch.tilt <= it.tilt;
    in_ch.point_contact <= it.point_contact;
    in_ch.spin_rate <= it.spin_rate;
    in_ch.contact_x <= it.contact_x;
    in_ch.contact_y <= it.contact_y;
    in_ch.contact_z <= it.contact_z;
    in_ch.apex_x <= it.apex_x;
    in_ch.apex_y <= it.apex_y;
    in_ch.apex_z <= it.apex_z;
    in_ch.stamp <= it.stamp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Hold the input until every predicted command has come out, then let the pipe empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic load_config(input int tmin, input int slim, input int cosv, input int sinv);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgTiltMin;
    cfg_data_i <= tmin[15:0];
    @(posedge clk_i);
    cfg_idx_i <= CfgSpinLimit;
    cfg_data_i <= slim[15:0];
    @(posedge clk_i);
    cfg_idx_i <= CfgCosStep;
    cfg_data_i <= cosv[15:0];
    @(posedge clk_i);
    cfg_idx_i <= CfgSinStep;
    cfg_data_i <= sinv[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_tilt_min = tmin;
    cur_spin_limit = slim;
  endtask

  task automatic load_random_config();
    load_config($urandom_range(3000), $urandom_range(32767, 1),
                int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
  endtask

  // Runs under the reset thresholds (tilt 715, spin 2048).
  task automatic run_directed();
    cone_item_t it;
    send_item(pick_sample(ModeQstatic));      // planning off: no command
    send_item(pick_trigger());                // planning on
    it = pick_sample(ModeQstatic);
    it.tilt = 16'sh7FFF;
    it.contact_x = 24'sh800000;
    it.contact_y = 24'sh7FFFFF;
    it.contact_z = 24'sh7FFFFF;
    it.apex_x = 24'sh7FFFFF;
    it.apex_y = 24'sh800000;
    it.apex_z = 24'sh800000;
    it.stamp = '1;
    send_item(it);                            // new command, saturated
    send_item(pick_sample(ModeQstatic));      // re-emit of pending
    send_item(pick_trigger());                // acknowledge
    it = pick_sample(ModeRocking);
    it.spin_rate = 16'sh8000;
    send_item(it);
    it = pick_sample(ModeRocking);
    it.spin_rate = 16'sd2048;                 // rate equal to limit rocks
    send_item(it);
    it = pick_sample(ModeQstatic);
    it.spin_rate = -16'sd2047;
    it.tilt = 16'sd715;                       // tilt equal to threshold
    send_item(it);                            // step count advances
    send_item(pick_trigger());
    it = pick_sample(ModeQstatic);
    it.spin_rate = 16'sd2047;
    it.contact_x = 24'sh800000;
    it.contact_y = 24'sh800000;
    it.contact_z = 24'sh800000;
    it.apex_x = 24'sh7FFFFF;
    it.apex_y = 24'sh7FFFFF;
    it.apex_z = 24'sh7FFFFF;
    send_item(it);
    send_item(pick_trigger());
    it = pick_sample(ModeIdle);
    it.point_contact = 1'b0;
    it.tilt = 16'sh7FFF;
    send_item(it);                            // no contact: leaves planning
    send_item(pick_sample(ModeQstatic));
    send_item(pick_trigger());
    it = pick_sample(ModeIdle);
    it.point_contact = 1'b1;
    it.tilt = 16'sd714;
    send_item(it);                            // quasi-static to idle
    send_item(pick_trigger());                // planning on while idle
    it = pick_sample(ModeIdle);
    it.point_contact = 1'b1;
    it.tilt = 16'sh8000;
    send_item(it);                            // idle to idle keeps planning
    send_item(pick_trigger());                // acknowledge with nothing pending
    send_item(pick_sample(ModeQstatic));
    send_item(pick_sample(ModeQstatic));
    send_item(pick_sample(ModeRocking));
  endtask

  task automatic run_random(input int n);
    cone_item_t it;
    int         r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 12) begin
        it = pick_trigger();
      end else if (r < 55) begin
        it = pick_sample(ModeQstatic);
      end else if (r < 80) begin
        it = pick_sample(ModeRocking);
      end else if (r < 92) begin
        it = pick_sample(ModeIdle);
      end else begin
        it = pick_trigger();
        it.cmd = $urandom_range(1) ? CmdTrigger : CmdSample;
      end
      send_item(it);
    end
  endtask

  initial begin
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgTiltMin;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdSample;
    in_ch.tilt = '0;
    in_ch.point_contact = 1'b0;
    in_ch.spin_rate = '0;
    in_ch.contact_x = '0;
    in_ch.contact_y = '0;
    in_ch.contact_z = '0;
    in_ch.apex_x = '0;
    in_ch.apex_y = '0;
    in_ch.apex_z = '0;
    in_ch.stamp = '0;
    cur_tilt_min = int'(TiltMinRst);
    cur_spin_limit = int'(SpinLimitRst);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_config(int'(TiltMinRst), int'(SpinLimitRst), int'(CosStepRst), int'(SinStepRst));
    run_directed();
    run_random(200);
    settle();
    load_config(0, 32767, 32767, -32768);
    run_random(180);
    settle();
    load_config(32767, 0, -32768, 32767);
    run_random(60);
    settle();
    load_config(1000, 1, -32768, -32768);
    run_random(120);
    settle();
    load_config(300, 6000, 0, 0);
    run_random(120);
    settle();
    calm = 1'b1;
    load_random_config();
    run_random(150);
    settle();
    calm = 1'b0;
    load_random_config();
    run_random(110);
    settle();
    load_random_config();
    run_random(110);
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rsp_pkg.sv
rtl/rsp_if.sv
rtl/rsp_front.sv
rtl/rsp_fifo.sv
rtl/rsp_back.sv
rtl/rocking_step_planner.sv
rtl/rsp_checker.sv
test/rsp_command_check.sv
test/rocking_step_planner_test.sv
